@@ hw/rtl/gmc_pkg.sv @@
`default_nettype none
package gmc_pkg;

	// sizes
	localparam int NUM_VERT   = 16;
	localparam int MAX_COLORS = 15;
	localparam int VIDX_W     = 4;
	localparam int VCNT_W     = 5;
	localparam int COLOR_W    = 4;
	localparam int CAND_W     = 5;
	localparam int CFG_DATA_W = 5;

	// reset values of the configuration registers
	localparam logic [COLOR_W-1:0] COLOR_LIMIT_RST  = 4'd3;
	localparam logic [VCNT_W-1:0]  VERTEX_COUNT_RST = 5'd0;

	// configuration register indexes
	localparam logic REG_COLOR_LIMIT  = 1'b0;
	localparam logic REG_VERTEX_COUNT = 1'b1;

	// item opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SOLVE = 1'b1;

	typedef struct packed {
		logic                  opcode;
		logic [VIDX_W-1:0]     row_index;
		logic [NUM_VERT-1:0]   row_bits;
	} item_t;

	typedef struct packed {
		logic [VIDX_W-1:0]  vertex;
		logic [COLOR_W-1:0] color;
		logic               success;
		logic               last;
	} result_t;

	// sequencer controls for the color store
	typedef struct packed {
		logic               clear_all;
		logic               set_en;
		logic [VIDX_W-1:0]  set_idx;
		logic [COLOR_W-1:0] set_color;
		logic               pm_en;
		logic [VIDX_W-1:0]  pm_idx;
		logic [COLOR_W-1:0] pm_val;
	} color_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/graph_m_coloring_backtrack.sv @@
// Load item: busy stays low, no result.
// Solve item: a setup step per vertex visit, then candidate colors tested one at a time by the
// shared safety check, and a further step when a vertex runs out of colors; exponential worst case.
// Results follow back to back, one per cycle, n of them on success (one if n is zero, one on failure).
// Reset (async, active low) clears the sequencer, colors and registers (limit 3, count 0).
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
module graph_m_coloring_backtrack (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic                           cfg_index,
	input  wire logic [gmc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           start,
	input  wire gmc_pkg::item_t                 item,
	output logic                                busy,
	output logic                                result_valid,
	output gmc_pkg::result_t                    result
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_TRY   = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]                        state_q;
	logic [gmc_pkg::COLOR_W-1:0]       limit_q;
	logic [gmc_pkg::VCNT_W-1:0]        count_q;
	logic [gmc_pkg::VCNT_W-1:0]        n_q;
	logic [gmc_pkg::COLOR_W-1:0]       m_q;
	logic [gmc_pkg::VCNT_W-1:0]        v_q;
	logic [gmc_pkg::VIDX_W-1:0]        k_q;
	logic [gmc_pkg::CAND_W-1:0]        cand_q;
	logic [gmc_pkg::CAND_W-1:0]        top_q;
	logic [gmc_pkg::NUM_VERT-1:0]      row_q;
	logic [gmc_pkg::NUM_VERT-1:0]      adj_q [gmc_pkg::NUM_VERT];
	logic                              res_valid_q;
	gmc_pkg::result_t                  res_q;

	gmc_pkg::color_ctl_t               ctl;
	logic [gmc_pkg::VIDX_W-1:0]        rd_idx;
	logic                              safe;
	logic [gmc_pkg::COLOR_W-1:0]       color_rd;
	logic [gmc_pkg::COLOR_W-1:0]       pm_rd;
	logic                              accept;
	logic [gmc_pkg::CAND_W-1:0]        top_raw;
	logic                              last_k;

	assign cfg_ready    = 1'b1;
	assign busy         = (state_q != ST_IDLE);
	assign accept       = start && !busy;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign rd_idx  = (state_q == ST_EMIT) ? k_q : v_q[gmc_pkg::VIDX_W-1:0];
	assign top_raw = {1'b0, pm_rd} + gmc_pkg::CAND_W'(1);
	assign last_k  = ({1'b0, k_q} + gmc_pkg::VCNT_W'(1)) == n_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= gmc_pkg::COLOR_LIMIT_RST;
			count_q <= gmc_pkg::VERTEX_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gmc_pkg::REG_COLOR_LIMIT:  limit_q <= cfg_data[gmc_pkg::COLOR_W-1:0];
				gmc_pkg::REG_VERTEX_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// adjacency rows, undefined until loaded
	always_ff @(posedge clk) begin
		if (accept && item.opcode == gmc_pkg::OP_LOAD) begin
			adj_q[item.row_index] <= item.row_bits;
		end
	end

	// color store controls
	always_comb begin
		ctl = '0;
		ctl.clear_all = accept && item.opcode == gmc_pkg::OP_SOLVE;
		case (state_q)
			ST_SETUP: begin
				if (v_q != n_q) begin
					ctl.set_en  = 1'b1;
					ctl.set_idx = v_q[gmc_pkg::VIDX_W-1:0];
				end
			end
			ST_TRY: begin
				if (cand_q <= top_q && safe) begin
					ctl.set_en    = 1'b1;
					ctl.set_idx   = v_q[gmc_pkg::VIDX_W-1:0];
					ctl.set_color = cand_q[gmc_pkg::COLOR_W-1:0];
					ctl.pm_en     = (v_q + gmc_pkg::VCNT_W'(1)) < gmc_pkg::VCNT_W'(gmc_pkg::NUM_VERT);
					ctl.pm_idx    = gmc_pkg::VIDX_W'(v_q + gmc_pkg::VCNT_W'(1));
					ctl.pm_val    = (cand_q[gmc_pkg::COLOR_W-1:0] > pm_rd)
						? cand_q[gmc_pkg::COLOR_W-1:0] : pm_rd;
				end
			end
			default: ;
		endcase
	end

	gmc_unit u_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rd_idx   (rd_idx),
		.row      (row_q),
		.n        (n_q),
		.cand     (cand_q),
		.safe     (safe),
		.color_rd (color_rd),
		.pm_rd    (pm_rd)
	);

	// search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			m_q         <= '0;
			v_q         <= '0;
			k_q         <= '0;
			cand_q      <= '0;
			top_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && item.opcode == gmc_pkg::OP_SOLVE) begin
						n_q <= (count_q > gmc_pkg::VCNT_W'(gmc_pkg::NUM_VERT))
							? gmc_pkg::VCNT_W'(gmc_pkg::NUM_VERT) : count_q;
						m_q <= (limit_q > gmc_pkg::COLOR_W'(gmc_pkg::MAX_COLORS))
							? gmc_pkg::COLOR_W'(gmc_pkg::MAX_COLORS) : limit_q;
						v_q     <= '0;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (v_q == n_q) begin
						k_q     <= '0;
						state_q <= ST_EMIT;
					end else begin
						cand_q  <= {1'b0, color_rd} + gmc_pkg::CAND_W'(1);
						top_q   <= (top_raw > {1'b0, m_q}) ? {1'b0, m_q} : top_raw;
						state_q <= ST_TRY;
					end
				end
				ST_TRY: begin
					if (cand_q > top_q) begin
						// no color left: step back or give up
						if (v_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							v_q     <= v_q - gmc_pkg::VCNT_W'(1);
							state_q <= ST_SETUP;
						end
					end else if (safe) begin
						v_q     <= v_q + gmc_pkg::VCNT_W'(1);
						state_q <= ST_SETUP;
					end else begin
						cand_q <= cand_q + gmc_pkg::CAND_W'(1);
					end
				end
				ST_EMIT: begin
					if (n_q == '0 || last_k) begin
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + gmc_pkg::VIDX_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result strobe: every emit cycle, or the search giving up at vertex zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (state_q == ST_EMIT)
				|| (state_q == ST_TRY && cand_q > top_q && v_q == '0);
		end
	end

	// adjacency row of the vertex being colored
	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			row_q <= adj_q[v_q[gmc_pkg::VIDX_W-1:0]];
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_TRY) begin
			res_q <= '{vertex: '0, color: '0, success: 1'b0, last: 1'b1};
		end else if (state_q == ST_EMIT) begin
			if (n_q == '0) begin
				res_q <= '{vertex: '0, color: '0, success: 1'b1, last: 1'b1};
			end else begin
				res_q <= '{vertex: k_q, color: color_rd, success: 1'b1, last: last_k};
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/gmc_unit.sv @@
`default_nettype none
module gmc_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire gmc_pkg::color_ctl_t          ctl,
	input  wire logic [gmc_pkg::VIDX_W-1:0]   rd_idx,
	input  wire logic [gmc_pkg::NUM_VERT-1:0] row,
	input  wire logic [gmc_pkg::VCNT_W-1:0]   n,
	input  wire logic [gmc_pkg::CAND_W-1:0]   cand,
	output logic                              safe,
	output logic [gmc_pkg::COLOR_W-1:0]       color_rd,
	output logic [gmc_pkg::COLOR_W-1:0]       pm_rd
);

	logic [gmc_pkg::COLOR_W-1:0] colors_q [gmc_pkg::NUM_VERT];
	// largest color among the vertices below each index
	logic [gmc_pkg::COLOR_W-1:0] pmax_q [gmc_pkg::NUM_VERT];
	logic [gmc_pkg::NUM_VERT-1:0] hit;

	// vertex colors, cleared at the start of every search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gmc_pkg::NUM_VERT; i++) begin
				colors_q[i] <= '0;
			end
		end else if (ctl.clear_all) begin
			for (int i = 0; i < gmc_pkg::NUM_VERT; i++) begin
				colors_q[i] <= '0;
			end
		end else if (ctl.set_en) begin
			colors_q[ctl.set_idx] <= ctl.set_color;
		end
	end

	// prefix maximum, entry zero always reads as zero
	always_ff @(posedge clk) begin
		if (ctl.pm_en) begin
			pmax_q[ctl.pm_idx] <= ctl.pm_val;
		end
	end

	assign color_rd = colors_q[rd_idx];
	assign pm_rd    = (rd_idx == '0) ? '0 : pmax_q[rd_idx];

	// one safety check per cycle: any colored neighbor below n with this color
	always_comb begin
		for (int i = 0; i < gmc_pkg::NUM_VERT; i++) begin
			hit[i] = row[i] && (gmc_pkg::VCNT_W'(i) < n) && !cand[gmc_pkg::CAND_W-1]
				&& (colors_q[i] == cand[gmc_pkg::COLOR_W-1:0]);
		end
		safe = ~|hit;
	end

endmodule
`default_nettype wire

@@ hw/rtl/gmc_checker.sv @@
`default_nettype none
module gmc_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire gmc_pkg::item_t                 item,
	input  wire logic                           busy,
	input  wire logic                           result_valid,
	input  wire gmc_pkg::result_t               result
);

	// a failed run gives one closing item with no color
	a_fail_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.success |-> result.last && result.color == '0)
		else $error("failure item malformed");

	// items of a run come back to back with rising vertex numbers
	a_run_next: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result_valid
			&& result.vertex == gmc_pkg::VIDX_W'($past(result.vertex) + 1'b1))
		else $error("run items not contiguous");

	// the block stays busy until the last item of a run is out
	a_busy_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy)
		else $error("not busy in the middle of a run");

	// a row load finishes at once and gives no item
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.opcode == gmc_pkg::OP_LOAD |=> !busy && !result_valid)
		else $error("row load not silent");

	// colors on success stay nonzero, apart from the lone item of an empty graph
	a_color_set: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.success && result.color == '0 |->
			result.last && result.vertex == '0)
		else $error("uncolored vertex in a successful run");

endmodule

bind graph_m_coloring_backtrack gmc_checker u_gmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.item         (item),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
`default_nettype wire
